@@ hw/rtl/i2p_pkg.sv @@
// ----------------------------------------------------------------------------
// i2p_pkg: shared definitions for the infix to postfix converter
// token codes, operator codes, status codes, precedence helpers
// ----------------------------------------------------------------------------
package i2p_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 16;

	// field widths
	localparam int KIND_W   = 3;
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int OKIND_W  = 2;
	localparam int STATUS_W = 2;
	localparam int PREC_W   = 2;

	// packed stream widths
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	// input token kinds
	localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OPER   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

	// operator codes; an open bracket on the stack uses its own code
	localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
	localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
	localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
	localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
	localparam logic [OP_W-1:0] OP_POWER  = 3'd4;
	localparam logic [OP_W-1:0] OPEN_MARK = 3'd5;

	// result kinds
	localparam logic [OKIND_W-1:0] OUT_NUMBER = 2'd0;
	localparam logic [OKIND_W-1:0] OUT_OPER   = 2'd1;
	localparam logic [OKIND_W-1:0] OUT_STATUS = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNM_CLOSE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNM_OPEN  = 2'd3;

	// shift control handed to every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	function automatic logic [PREC_W-1:0] prec_of(input logic [OP_W-1:0] code);
		logic [PREC_W-1:0] p;
		begin
			case (code)
				OP_PLUS, OP_MINUS:   p = 2'd1;
				OP_TIMES, OP_DIVIDE: p = 2'd2;
				OP_POWER:            p = 2'd3;
				default:             p = 2'd0;
			endcase
			return p;
		end
	endfunction

	// does a stacked entry give way to an incoming operator of precedence p
	function automatic logic pops_for(input logic [OP_W-1:0] top,
	                                  input logic [PREC_W-1:0] p);
		logic [PREC_W-1:0] tp;
		begin
			tp = prec_of(top);
			return (tp > p) || ((top != OP_POWER) && (tp == p) && (tp != 2'd0));
		end
	endfunction

endpackage

@@ hw/rtl/i2p_cell.sv @@
// ----------------------------------------------------------------------------
// i2p_cell: one entry of the shifting operator stack
// takes the upper neighbor on push, the lower neighbor on pop
// ----------------------------------------------------------------------------
module i2p_cell (
	input  logic                       clk,
	input  i2p_pkg::cell_ctrl_t        ctrl,
	input  logic [i2p_pkg::OP_W-1:0]   upper,
	input  logic [i2p_pkg::OP_W-1:0]   lower,
	output logic [i2p_pkg::OP_W-1:0]   data
);

	logic [i2p_pkg::OP_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= upper;
		end else if (ctrl.pop) begin
			data_q <= lower;
		end
	end

	assign data = data_q;

endmodule

@@ hw/rtl/infix_to_postfix_converter_unit.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard token converter
// turns a stream of infix tokens into postfix tokens and status items
// ----------------------------------------------------------------------------
// One token is taken per input transfer (tuser = kind). Numbers come out
// unchanged; operators and brackets go through an operator stack built as a
// row of cells that shift down on push and up on pop, so the top entry is
// always in cell 0. The unit works on one token at a time: the token is
// taken, then every further cycle does one step (the number result, one
// pop with or without a result, one push, or one status result); a stalled
// output holds the step in place. End of expression always yields a status
// result (ok or unmatched open); overflow and an unmatched close also give
// status results and empty the stack. Kinds 5..7 and operator codes 5..7
// are taken and dropped without any stack step. The final result of each
// token carries tlast.
module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input token stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [i2p_pkg::S_DATA_W-1:0]   s_tdata,  // op_code[2:0], number_value[34:3], zero fill
	input  logic [i2p_pkg::KIND_W-1:0]     s_tuser,  // kind[2:0]
	// output token stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [i2p_pkg::M_DATA_W-1:0]   m_tdata,  // out_op[2:0], out_value[34:3], status[36:35], zero fill
	output logic [i2p_pkg::OKIND_W-1:0]    m_tuser,  // out_kind[1:0]
	output logic                           m_tlast
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int OP_W  = i2p_pkg::OP_W;

	// controller states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WORK = 1'b1;

	logic state_q;

	// latched token
	logic [i2p_pkg::KIND_W-1:0]  kind_q;
	logic [OP_W-1:0]             op_q;
	logic [i2p_pkg::VALUE_W-1:0] value_q;

	// stack fill
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic                           out_valid_q;
	logic [i2p_pkg::OKIND_W-1:0]    out_kind_q;
	logic [OP_W-1:0]                out_op_q;
	logic [i2p_pkg::VALUE_W-1:0]    out_value_q;
	logic [i2p_pkg::STATUS_W-1:0]   out_status_q;
	logic                           out_last_q;

	// input field split
	logic [OP_W-1:0]             in_op;
	logic [i2p_pkg::VALUE_W-1:0] in_value;
	logic                        in_xfer;
	logic                        in_useful;

	assign in_op    = s_tdata[OP_W-1:0];
	assign in_value = s_tdata[OP_W +: i2p_pkg::VALUE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// invalid kinds and invalid operators are dropped at the door
	always_comb begin
		unique case (s_tuser) inside
			i2p_pkg::KIND_NUMBER, i2p_pkg::KIND_OPEN,
			i2p_pkg::KIND_CLOSE, i2p_pkg::KIND_END: in_useful = 1'b1;
			i2p_pkg::KIND_OPER:                     in_useful = (in_op <= i2p_pkg::OP_POWER);
			default:                                in_useful = 1'b0;
		endcase
	end

	// stack cells
	logic [OP_W-1:0]     cell_data [STACK_DEPTH];
	logic [OP_W-1:0]     push_data;
	i2p_pkg::cell_ctrl_t cell_ctrl;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [OP_W-1:0] upper;
		logic [OP_W-1:0] lower;
		if (i == 0) begin : g_top
			assign upper = push_data;
		end else begin : g_mid
			assign upper = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign lower = '0;
		end else begin : g_rest
			assign lower = cell_data[i+1];
		end
		i2p_cell u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.upper (upper),
			.lower (lower),
			.data  (cell_data[i])
		);
	end

	// step decision
	logic [OP_W-1:0]              top_code;
	logic [OP_W-1:0]              next_code;
	logic [i2p_pkg::PREC_W-1:0]   in_prec;
	logic                         stack_nz;
	logic                         stack_more;
	logic                         stack_full;
	logic                         out_free;
	logic                         advance;
	logic                         do_push;
	logic                         do_pop;
	logic                         do_clear;
	logic                         do_done;
	logic                         emit;
	logic [i2p_pkg::OKIND_W-1:0]  emit_kind;
	logic [OP_W-1:0]              emit_op;
	logic [i2p_pkg::VALUE_W-1:0]  emit_value;
	logic [i2p_pkg::STATUS_W-1:0] emit_status;
	logic                         emit_last;

	assign top_code   = cell_data[0];
	assign next_code  = cell_data[1];
	assign in_prec    = i2p_pkg::prec_of(op_q);
	assign stack_nz   = (cnt_q != '0);
	assign stack_more = (cnt_q > CNT_W'(1));
	assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign out_free   = !out_valid_q || m_tready;
	assign advance    = (state_q == ST_WORK) && out_free;

	always_comb begin
		do_push     = 1'b0;
		do_pop      = 1'b0;
		do_clear    = 1'b0;
		do_done     = 1'b0;
		emit        = 1'b0;
		emit_kind   = i2p_pkg::OUT_STATUS;
		emit_op     = '0;
		emit_value  = '0;
		emit_status = i2p_pkg::ST_OK;
		emit_last   = 1'b0;
		push_data   = op_q;
		unique case (kind_q)
			i2p_pkg::KIND_NUMBER: begin
				emit       = 1'b1;
				emit_kind  = i2p_pkg::OUT_NUMBER;
				emit_value = value_q;
				emit_last  = 1'b1;
				do_done    = 1'b1;
			end
			i2p_pkg::KIND_OPER: begin
				if (stack_nz && i2p_pkg::pops_for(top_code, in_prec)) begin
					// last pop when the entry below will not give way
					do_pop    = 1'b1;
					emit      = 1'b1;
					emit_kind = i2p_pkg::OUT_OPER;
					emit_op   = top_code;
					emit_last = !(stack_more && i2p_pkg::pops_for(next_code, in_prec));
				end else if (stack_full) begin
					do_clear    = 1'b1;
					emit        = 1'b1;
					emit_status = i2p_pkg::ST_OVERFLOW;
					emit_last   = 1'b1;
					do_done     = 1'b1;
				end else begin
					do_push = 1'b1;
					do_done = 1'b1;
				end
			end
			i2p_pkg::KIND_OPEN: begin
				push_data = i2p_pkg::OPEN_MARK;
				if (stack_full) begin
					do_clear    = 1'b1;
					emit        = 1'b1;
					emit_status = i2p_pkg::ST_OVERFLOW;
					emit_last   = 1'b1;
				end else begin
					do_push = 1'b1;
				end
				do_done = 1'b1;
			end
			i2p_pkg::KIND_CLOSE: begin
				if (stack_nz && (top_code != i2p_pkg::OPEN_MARK)) begin
					// final result only if the matching bracket sits right below
					do_pop    = 1'b1;
					emit      = 1'b1;
					emit_kind = i2p_pkg::OUT_OPER;
					emit_op   = top_code;
					emit_last = stack_more && (next_code == i2p_pkg::OPEN_MARK);
				end else if (stack_nz) begin
					do_pop  = 1'b1;
					do_done = 1'b1;
				end else begin
					emit        = 1'b1;
					emit_status = i2p_pkg::ST_UNM_CLOSE;
					emit_last   = 1'b1;
					do_done     = 1'b1;
				end
			end
			i2p_pkg::KIND_END: begin
				if (stack_nz && (top_code != i2p_pkg::OPEN_MARK)) begin
					// a status result always follows the flush
					do_pop    = 1'b1;
					emit      = 1'b1;
					emit_kind = i2p_pkg::OUT_OPER;
					emit_op   = top_code;
				end else if (stack_nz) begin
					do_clear    = 1'b1;
					emit        = 1'b1;
					emit_status = i2p_pkg::ST_UNM_OPEN;
					emit_last   = 1'b1;
					do_done     = 1'b1;
				end else begin
					emit        = 1'b1;
					emit_status = i2p_pkg::ST_OK;
					emit_last   = 1'b1;
					do_done     = 1'b1;
				end
			end
			default: begin
				do_done = 1'b1;
			end
		endcase
	end

	assign cell_ctrl.push = advance && do_push;
	assign cell_ctrl.pop  = advance && do_pop;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_useful) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (advance && do_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (advance) begin
				if (do_clear) begin
					cnt_q <= '0;
				end else if (do_push) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (do_pop) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// token and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= s_tuser;
			op_q    <= in_op;
			value_q <= in_value;
		end
		if (advance && emit) begin
			out_kind_q   <= emit_kind;
			out_op_q     <= emit_op;
			out_value_q  <= emit_value;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {
		(i2p_pkg::M_DATA_W - OP_W - i2p_pkg::VALUE_W - i2p_pkg::STATUS_W)'(0),
		out_status_q, out_value_q, out_op_q
	};

endmodule
